/* design/lbs_pkg.sv */
package lbs_pkg;

	localparam int SRC_DEPTH   = 65536;
	localparam int SRC_ADDR_W  = 16;
	localparam int SURFACE_MAX = 1024;
	localparam int COLOR_W     = 24;
	localparam int QUOT_W      = 9;
	localparam int NUM_W       = 20;
	localparam int DIV_STEPS   = 9;
	localparam int GDIV_W      = 20;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_PIXEL = 1'b1
	} lbs_op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_BAD_SURFACE = 2'd1,
		ST_OUTSIDE     = 2'd2
	} lbs_status_t;

	typedef enum logic [2:0] {
		REG_SRC_W    = 3'd0,
		REG_SRC_H    = 3'd1,
		REG_STRIDE   = 3'd2,
		REG_SURF_W   = 3'd3,
		REG_SURF_H   = 3'd4,
		REG_MARGIN   = 3'd5,
		REG_FILL     = 3'd6
	} lbs_reg_t;

	typedef enum logic [2:0] {
		G_IDLE,
		G_FIT,
		G_CMP,
		G_DIV,
		G_SET,
		G_ORG
	} lbs_gstate_t;

	typedef struct packed {
		logic        operation;
		logic [15:0] load_index;
		logic [23:0] load_color;
		logic [9:0]  out_x;
		logic [9:0]  out_y;
	} lbs_in_t;

	typedef struct packed {
		logic [23:0] pixel_color;
		logic [1:0]  status;
	} lbs_out_t;

	typedef struct packed {
		logic [8:0]  src_w;
		logic [8:0]  src_h;
		logic [8:0]  stride;
		logic [10:0] surf_w;
		logic [10:0] surf_h;
		logic [7:0]  margin;
		logic [23:0] fill;
	} lbs_cfg_t;

	typedef struct packed {
		logic [8:0]  sw;
		logic [8:0]  sh;
		logic [10:0] dw;
		logic [10:0] dh;
		logic [10:0] ox;
		logic [10:0] oy;
	} lbs_geom_t;

	typedef struct packed {
		lbs_op_t                 op;
		lbs_status_t             status;
		logic                    in_rect;
		logic                    addr_ok;
		logic [SRC_ADDR_W-1:0]   load_index;
		logic [COLOR_W-1:0]      load_color;
		logic [9:0]              x;
		logic [9:0]              y;
		logic [NUM_W-1:0]        rx;
		logic [NUM_W-1:0]        ry;
		logic [QUOT_W-1:0]       qx;
		logic [QUOT_W-1:0]       qy;
		logic [SRC_ADDR_W-1:0]   addr;
	} lbs_pipe_t;

endpackage

/* design/letterbox_nearest_scaler.sv */
// Letterbox nearest-neighbor scaler. Load requests (operation 0) write one pixel of the
// source image into a 64K-entry store and give no result; pixel requests (operation 1)
// give one result each, in order. The datapath is a 15-stage pipeline: one request enters
// every clock when nothing stalls. The two coordinate divisions take one quotient bit per
// stage over nine stages. After reset and after every configuration write the fitted image
// rectangle is recomputed by a sequential unit, and in_stall stays high meanwhile: through
// the fit, compare and origin states when the image fits, with the 20-step divider and the
// set state between them when it must shrink.
module letterbox_nearest_scaler import lbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  lbs_in_t   in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output lbs_out_t  out_data,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [23:0] cfg_data
);

	lbs_cfg_t  cfg_q;
	lbs_geom_t geom;
	logic      geom_busy;
	logic      cfg_wr, accept;

	lbs_pipe_t p_s1, p_s2, p_s3, p_s13, p_s14;
	logic      v_s1, v_s2, v_s3, v_s13, v_s14;
	lbs_pipe_t div_p_s [DIV_STEPS];
	logic      div_v_s [DIV_STEPS];
	lbs_pipe_t div_in  [DIV_STEPS];
	lbs_pipe_t div_out [DIV_STEPS];
	logic      rdy_div [DIV_STEPS];
	logic      rdy_s1, rdy_s2, rdy_s3, rdy_s13, rdy_s14, rdy_out;

	lbs_pipe_t n_s1, n_s2, n_s3, n_s13;
	logic [10:0] x11, y11;
	logic        surf_bad;
	logic [18:0] addr_full;

	logic               out_v_q;
	lbs_out_t           out_q;
	logic [COLOR_W-1:0] ram_rdata, color;
	logic               ram_en, ram_we;
	logic [SRC_ADDR_W-1:0] ram_addr;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && cfg_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{src_w: 9'd1, src_h: 9'd1, stride: 9'd1, surf_w: 11'd760,
				surf_h: 11'd540, margin: 8'd12, fill: 24'h303030};
		end else if (cfg_wr) begin
			unique case (lbs_reg_t'(cfg_index))
				REG_SRC_W:  cfg_q.src_w  <= cfg_data[8:0];
				REG_SRC_H:  cfg_q.src_h  <= cfg_data[8:0];
				REG_STRIDE: cfg_q.stride <= cfg_data[8:0];
				REG_SURF_W: cfg_q.surf_w <= cfg_data[10:0];
				REG_SURF_H: cfg_q.surf_h <= cfg_data[10:0];
				REG_MARGIN: cfg_q.margin <= cfg_data[7:0];
				REG_FILL:   cfg_q.fill   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lbs_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_wr),
		.cfg    (cfg_q),
		.busy   (geom_busy),
		.geom   (geom)
	);

	// ready chain, bubbles collapse
	assign rdy_out = !out_v_q || !out_stall;
	assign rdy_s14 = !v_s14 || rdy_out;
	assign rdy_s13 = !v_s13 || rdy_s14;
	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			if (k == DIV_STEPS - 1) begin
				rdy_div[k] = !div_v_s[k] || rdy_s13;
			end else begin
				rdy_div[k] = !div_v_s[k] || rdy_div[k+1];
			end
		end
	end
	assign rdy_s3 = !v_s3 || rdy_div[0];
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign in_stall = !rdy_s1 || geom_busy;
	assign accept = in_valid && !in_stall;

	// stage 1: request capture
	always_comb begin
		n_s1            = '0;
		n_s1.op         = lbs_op_t'(in_data.operation);
		n_s1.load_index = in_data.load_index;
		n_s1.load_color = in_data.load_color;
		n_s1.x          = in_data.out_x;
		n_s1.y          = in_data.out_y;
	end

	// stage 2: window test and offsets
	assign x11 = {1'b0, p_s1.x};
	assign y11 = {1'b0, p_s1.y};
	assign surf_bad = (cfg_q.surf_w == '0) || (cfg_q.surf_h == '0)
		|| (cfg_q.surf_w > 11'(SURFACE_MAX)) || (cfg_q.surf_h > 11'(SURFACE_MAX));

	always_comb begin
		n_s2 = p_s1;
		if (surf_bad) begin
			n_s2.status = ST_BAD_SURFACE;
		end else if (x11 >= cfg_q.surf_w || y11 >= cfg_q.surf_h) begin
			n_s2.status = ST_OUTSIDE;
		end else begin
			n_s2.status = ST_OK;
		end
		n_s2.in_rect = (x11 >= geom.ox) && ((x11 - geom.ox) < geom.dw)
			&& (y11 >= geom.oy) && ((y11 - geom.oy) < geom.dh);
		n_s2.x = 10'(x11 - geom.ox);
		n_s2.y = 10'(y11 - geom.oy);
	end

	// stage 3: scale numerators
	always_comb begin
		n_s3 = p_s2;
		n_s3.rx = NUM_W'(p_s2.x) * NUM_W'(geom.sw);
		n_s3.ry = NUM_W'(p_s2.y) * NUM_W'(geom.sh);
		n_s3.qx = '0;
		n_s3.qy = '0;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		if (k == 0) begin : g_first
			assign div_in[k] = p_s3;
		end else begin : g_next
			assign div_in[k] = div_p_s[k-1];
		end

		lbs_div_stage u_div (
			.din   (div_in[k]),
			.dw    (geom.dw),
			.dh    (geom.dh),
			.shift (4'(DIV_STEPS - 1 - k)),
			.dout  (div_out[k])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (rdy_div[k]) begin
				div_v_s[k] <= (k == 0) ? v_s3 : div_v_s[k-1 < 0 ? 0 : k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy_div[k]) begin
				div_p_s[k] <= div_out[k];
			end
		end
	end

	// stage 13: store address
	assign addr_full = 19'(div_p_s[DIV_STEPS-1].qy) * 19'(cfg_q.stride)
		+ 19'(div_p_s[DIV_STEPS-1].qx);

	always_comb begin
		n_s13 = div_p_s[DIV_STEPS-1];
		n_s13.addr = addr_full[SRC_ADDR_W-1:0];
		n_s13.addr_ok = (addr_full[18:SRC_ADDR_W] == '0);
	end

	// stage 14: store access, loads write in request order
	assign ram_en = v_s13 && rdy_s14;
	assign ram_we = (p_s13.op == OP_LOAD);
	assign ram_addr = ram_we ? p_s13.load_index : p_s13.addr;

	lbs_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (SRC_DEPTH)
	) u_store (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (p_s13.load_color),
		.rdata (ram_rdata)
	);

	always_comb begin
		if (p_s14.status != ST_OK) begin
			color = '0;
		end else if (p_s14.in_rect) begin
			color = p_s14.addr_ok ? ram_rdata : '0;
		end else begin
			color = cfg_q.fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s13   <= 1'b0;
			v_s14   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= accept;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s13) begin
				v_s13 <= div_v_s[DIV_STEPS-1];
			end
			if (rdy_s14) begin
				v_s14 <= v_s13;
			end
			if (rdy_out) begin
				out_v_q <= v_s14 && (p_s14.op == OP_PIXEL);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			p_s1 <= n_s1;
		end
		if (rdy_s2) begin
			p_s2 <= n_s2;
		end
		if (rdy_s3) begin
			p_s3 <= n_s3;
		end
		if (rdy_s13) begin
			p_s13 <= n_s13;
		end
		if (rdy_s14) begin
			p_s14 <= p_s13;
		end
		if (rdy_out) begin
			out_q <= '{pixel_color: color, status: 2'(p_s14.status)};
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_err_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.status != ST_OK |-> out_q.pixel_color == '0)
		else $error("error status with nonzero color");

	a_s14_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s14 && !rdy_s14 |=> v_s14 && $stable(p_s14))
		else $error("store stage lost a stalled request");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 && p_s13.op == OP_PIXEL && p_s13.status == ST_OK && p_s13.in_rect
		|-> p_s13.rx < NUM_W'(geom.dw) && p_s13.ry < NUM_W'(geom.dh))
		else $error("divider remainder out of range");

	a_geom_fit: assert property (@(posedge clk) disable iff (!arst_n)
		!geom_busy && !surf_bad |-> geom.dw != '0 && geom.dw <= cfg_q.surf_w
		&& geom.dh != '0 && geom.dh <= cfg_q.surf_h)
		else $error("fitted rectangle exceeds surface");

endmodule

/* design/lbs_ram.sv */
module lbs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* design/lbs_geom.sv */
module lbs_geom import lbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  lbs_cfg_t  cfg,
	output logic      busy,
	output lbs_geom_t geom
);

	lbs_gstate_t        state_q, state_d;
	logic [4:0]         cnt_q;
	logic [8:0]         sw_q, sh_q, den_q, rem_q;
	logic [10:0]        aw_q, ah_q, dw_q, dh_q, ox_q, oy_q;
	logic [GDIV_W-1:0]  num_q, quo_q;
	logic               wide_q;
	logic [8:0]         twice;
	logic [19:0]        p_wa, p_hw;
	logic [9:0]         trial;
	logic               take;
	logic [10:0]        q_clamped;

	assign twice = {cfg.margin, 1'b0};
	assign p_wa = 20'(sw_q) * 20'(ah_q);
	assign p_hw = 20'(sh_q) * 20'(aw_q);
	assign trial = {rem_q, num_q[GDIV_W-1]};
	assign take = trial >= {1'b0, den_q};
	assign q_clamped = (quo_q == '0) ? 11'd1 : quo_q[10:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			G_IDLE: state_d = G_IDLE;
			G_FIT:  state_d = G_CMP;
			G_CMP: begin
				if (11'(sw_q) <= aw_q && 11'(sh_q) <= ah_q) begin
					state_d = G_ORG;
				end else begin
					state_d = G_DIV;
				end
			end
			G_DIV: begin
				if (cnt_q == 5'(GDIV_W - 1)) begin
					state_d = G_SET;
				end
			end
			G_SET:  state_d = G_ORG;
			G_ORG:  state_d = G_IDLE;
			default: state_d = G_FIT;
		endcase
		if (start) begin
			state_d = G_FIT;
		end
	end

	always_comb begin
		busy = (state_q != G_IDLE);
		geom = '{sw: sw_q, sh: sh_q, dw: dw_q, dh: dh_q, ox: ox_q, oy: oy_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_FIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			G_FIT: begin
				sw_q <= (cfg.src_w == '0) ? 9'd1 : cfg.src_w;
				sh_q <= (cfg.src_h == '0) ? 9'd1 : cfg.src_h;
				aw_q <= (cfg.surf_w > 11'(twice)) ? cfg.surf_w - 11'(twice) : 11'd1;
				ah_q <= (cfg.surf_h > 11'(twice)) ? cfg.surf_h - 11'(twice) : 11'd1;
			end
			G_CMP: begin
				dw_q  <= 11'(sw_q);
				dh_q  <= 11'(sh_q);
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
				if (p_wa > p_hw) begin
					wide_q <= 1'b1;
					num_q  <= p_hw;
					den_q  <= sw_q;
				end else begin
					wide_q <= 1'b0;
					num_q  <= p_wa;
					den_q  <= sh_q;
				end
			end
			G_DIV: begin
				rem_q <= take ? 9'(trial - {1'b0, den_q}) : trial[8:0];
				quo_q <= {quo_q[GDIV_W-2:0], take};
				num_q <= {num_q[GDIV_W-2:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
			end
			G_SET: begin
				if (wide_q) begin
					dw_q <= aw_q;
					dh_q <= q_clamped;
				end else begin
					dh_q <= ah_q;
					dw_q <= q_clamped;
				end
			end
			G_ORG: begin
				ox_q <= (cfg.surf_w - dw_q) >> 1;
				oy_q <= (cfg.surf_h - dh_q) >> 1;
			end
			default: begin
			end
		endcase
	end

endmodule

/* design/lbs_div_stage.sv */
module lbs_div_stage import lbs_pkg::*; (
	input  lbs_pipe_t   din,
	input  logic [10:0] dw,
	input  logic [10:0] dh,
	input  logic [3:0]  shift,
	output lbs_pipe_t   dout
);

	logic [NUM_W-1:0] dsx, dsy;

	assign dsx = NUM_W'(dw) << shift;
	assign dsy = NUM_W'(dh) << shift;

	always_comb begin
		dout = din;
		if (din.rx >= dsx) begin
			dout.rx = din.rx - dsx;
			dout.qx = din.qx | (QUOT_W'(1) << shift);
		end
		if (din.ry >= dsy) begin
			dout.ry = din.ry - dsy;
			dout.qy = din.qy | (QUOT_W'(1) << shift);
		end
	end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import lbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int PHASES         = 9;
	localparam int PHASE_ITEMS    = 128;
	localparam int IN_W           = $bits(lbs_in_t);

	typedef struct {
		bit          is_cfg;
		lbs_reg_t    reg_idx;
		int unsigned reg_val;
		lbs_op_t     op;
		int unsigned a;
		int unsigned b;
		bit          typed;
		int unsigned want_color;
		lbs_status_t want_status;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	lbs_in_t    in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	lbs_out_t   out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;

	lbs_out_t    pixel_expq[$];
	logic [23:0] src_img [0:SRC_DEPTH-1];
	bit          src_written [0:SRC_DEPTH-1];
	int unsigned c_src_w = 1, c_src_h = 1, c_stride = 1;
	int unsigned c_surf_w = 760, c_surf_h = 540, c_margin = 12, c_fill = 24'h303030;
	int          errors = 0;
	bit          idle_on = 1'b1;
	int          stall_left = 0;
	int          quiet_cycles = 0;
	int          sent = 0;

	dir_row_t dir_rows[] = '{
		'{0, REG_SRC_W, 0, OP_LOAD, 0, 24'hABCDEF, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 0, 0, 1, 24'h303030, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 379, 269, 1, 24'hABCDEF, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 1023, 1023, 1, 0, ST_OUTSIDE},
		'{0, REG_SRC_W, 0, OP_PIXEL, 759, 539, 1, 24'h303030, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 760, 0, 1, 0, ST_OUTSIDE},
		'{0, REG_SRC_W, 0, OP_PIXEL, 0, 540, 1, 0, ST_OUTSIDE},
		'{0, REG_SRC_W, 0, OP_LOAD, 16'hFFFF, 24'hFFFFFF, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 379, 269, 1, 0, ST_OK},
		'{1, REG_SURF_W, 0, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 0, 0, 1, 0, ST_BAD_SURFACE},
		'{1, REG_SURF_W, 1500, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 5, 5, 1, 0, ST_BAD_SURFACE},
		'{1, REG_SURF_W, 1024, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{1, REG_SURF_H, 1024, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{1, REG_MARGIN, 255, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 511, 511, 0, 0, ST_OK},
		'{1, REG_FILL, 24'hFFFFFF, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 0, 0, 1, 24'hFFFFFF, ST_OK},
		'{1, REG_SRC_W, 0, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{1, REG_SRC_H, 0, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 511, 511, 0, 0, ST_OK},
		'{1, REG_SRC_W, 256, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{1, REG_SRC_H, 256, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{1, REG_STRIDE, 256, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{1, REG_MARGIN, 0, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 639, 639, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 384, 384, 0, 0, ST_OK},
		'{1, REG_SURF_W, 1, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{1, REG_SURF_H, 1, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{1, REG_MARGIN, 12, OP_LOAD, 0, 0, 0, 0, ST_OK},
		'{0, REG_SRC_W, 0, OP_PIXEL, 0, 0, 0, 0, ST_OK}
	};

	letterbox_nearest_scaler DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic lbs_out_t scale_pixel(input int unsigned x, input int unsigned y,
			output int unsigned addr, output bit reads);
		lbs_out_t    r;
		int unsigned sw, sh, aw, ah, dw, dh, ox, oy, twice, sx, sy;
		reads = 0;
		addr = 0;
		r.pixel_color = '0;
		r.status = ST_OK;
		if (c_surf_w == 0 || c_surf_h == 0 || c_surf_w > SURFACE_MAX ||
				c_surf_h > SURFACE_MAX) begin
			r.status = ST_BAD_SURFACE;
			return r;
		end
		if (x >= c_surf_w || y >= c_surf_h) begin
			r.status = ST_OUTSIDE;
			return r;
		end
		sw = (c_src_w == 0) ? 1 : c_src_w;
		sh = (c_src_h == 0) ? 1 : c_src_h;
		twice = c_margin * 2;
		aw = (c_surf_w > twice) ? c_surf_w - twice : 1;
		ah = (c_surf_h > twice) ? c_surf_h - twice : 1;
		dw = sw;
		dh = sh;
		if (!(sw <= aw && sh <= ah)) begin
			if (sw * ah > sh * aw) begin
				dw = aw;
				dh = sh * aw / sw;
			end else begin
				dh = ah;
				dw = sw * ah / sh;
			end
			if (dw == 0) dw = 1;
			if (dh == 0) dh = 1;
		end
		ox = (c_surf_w - dw) / 2;
		oy = (c_surf_h - dh) / 2;
		r.pixel_color = c_fill[23:0];
		if (x >= ox && x - ox < dw && y >= oy && y - oy < dh) begin
			sx = (x - ox) * sw / dw;
			sy = (y - oy) * sh / dh;
			addr = sy * c_stride + sx;
			reads = (addr < SRC_DEPTH);
			r.pixel_color = reads ? src_img[addr] : 24'h0;
		end
		return r;
	endfunction

	task automatic push_request(input lbs_in_t it, input bit typed, input lbs_out_t want);
		int          gap;
		int unsigned addr;
		bit          reads;
		lbs_out_t    pred;
		gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
		if (it.operation == OP_LOAD) begin
			src_img[it.load_index] = it.load_color;
			src_written[it.load_index] = 1'b1;
		end else begin
			pred = scale_pixel(it.out_x, it.out_y, addr, reads);
			pixel_expq.push_back(typed ? want : pred);
		end
	endtask

	// a pixel request whose source pixel was never loaded gets a load first
	task automatic issue(input lbs_in_t it, input bit typed, input lbs_out_t want);
		int unsigned addr;
		bit          reads;
		lbs_out_t    pred;
		lbs_in_t     ld;
		if (it.operation == OP_PIXEL) begin
			pred = scale_pixel(it.out_x, it.out_y, addr, reads);
			if (reads && !src_written[addr]) begin
				ld = it;
				ld.operation = OP_LOAD;
				ld.load_index = addr[15:0];
				ld.load_color = 24'($urandom);
				push_request(ld, 1'b0, want);
			end
		end
		push_request(it, typed, want);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixel_expq.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input lbs_reg_t idx, input int unsigned val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[23:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_SRC_W:  c_src_w = val & 9'h1FF;
			REG_SRC_H:  c_src_h = val & 9'h1FF;
			REG_STRIDE: c_stride = val & 9'h1FF;
			REG_SURF_W: c_surf_w = val & 11'h7FF;
			REG_SURF_H: c_surf_h = val & 11'h7FF;
			REG_MARGIN: c_margin = val & 8'hFF;
			REG_FILL:   c_fill = val & 24'hFFFFFF;
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic int unsigned pick_src();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 256;
			3: return $urandom_range(1, 16);
			default: return $urandom_range(1, 256);
		endcase
	endfunction

	function automatic int unsigned pick_surf();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return $urandom_range(1025, 2047);
			2, 3: return 1;
			4, 5: return 1024;
			default: return $urandom_range(16, 1024);
		endcase
	endfunction

	always @(posedge clk) begin
		if (!idle_on) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 8);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		lbs_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_expq.size() == 0) begin
				$display("%0t: unexpected result color=%h status=%0d", $time,
					out_data.pixel_color, out_data.status);
				errors++;
			end else begin
				want = pixel_expq.pop_front();
				if (out_data.pixel_color !== want.pixel_color) begin
					$display("%0t: pixel_color expected %h actual %h", $time,
						want.pixel_color, out_data.pixel_color);
					errors++;
				end
				if (out_data.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time,
						want.status, out_data.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready) || !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		lbs_in_t  it;
		lbs_out_t want;
		int unsigned span;
		int       target;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				settle();
				write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
			end else begin
				it = IN_W'({$urandom, $urandom});
				it.operation = dir_rows[i].op;
				if (dir_rows[i].op == OP_LOAD) begin
					it.load_index = 16'(dir_rows[i].a);
					it.load_color = 24'(dir_rows[i].b);
				end else begin
					it.out_x = 10'(dir_rows[i].a);
					it.out_y = 10'(dir_rows[i].b);
				end
				want.pixel_color = 24'(dir_rows[i].want_color);
				want.status = dir_rows[i].want_status;
				issue(it, dir_rows[i].typed, want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			idle_on = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
			write_reg(REG_SRC_W, pick_src());
			write_reg(REG_SRC_H, pick_src());
			write_reg(REG_STRIDE, ($urandom_range(0, 2) == 0) ? 256 :
				(c_src_w == 0 ? 1 : c_src_w));
			write_reg(REG_SURF_W, pick_surf());
			write_reg(REG_SURF_H, pick_surf());
			case ($urandom_range(0, 4))
				0: write_reg(REG_MARGIN, 0);
				1: write_reg(REG_MARGIN, 255);
				default: write_reg(REG_MARGIN, $urandom_range(0, 64));
			endcase
			write_reg(REG_FILL, $urandom_range(0, 24'hFFFFFF));
			target = sent + PHASE_ITEMS;
			while (sent < target) begin
				it = IN_W'({$urandom, $urandom});
				if ($urandom_range(0, 9) < 3) begin
					it.operation = OP_LOAD;
					span = c_stride * (c_src_h == 0 ? 1 : c_src_h);
					if ($urandom_range(0, 1) == 0)
						it.load_index = 16'($urandom_range(0, span - 1));
				end else begin
					it.operation = OP_PIXEL;
					if ($urandom_range(0, 9) != 0 && c_surf_w >= 1 && c_surf_w <= SURFACE_MAX
							&& c_surf_h >= 1 && c_surf_h <= SURFACE_MAX) begin
						it.out_x = 10'($urandom_range(0, c_surf_w - 1));
						it.out_y = 10'($urandom_range(0, c_surf_h - 1));
					end
				end
				issue(it, 1'b0, want);
			end
		end

		settle();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
